>>> src/smm_pkg.sv
// shared types and constants for the segmented memory map
`default_nettype none
package smm_pkg;

    localparam int REG_SEGS   = 4;
    localparam int SEG_IDX_W  = 2;
    localparam int SIZE_W     = 13;
    localparam int VADDR_W    = 32;
    localparam int DATA_W     = 32;
    localparam int NUM_REGS   = 2 * REG_SEGS;
    localparam int CFG_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    typedef enum logic [1:0] {
        CMD_READ_BYTE  = 2'd0,
        CMD_WRITE_BYTE = 2'd1,
        CMD_READ_WORD  = 2'd2,
        CMD_WRITE_WORD = 2'd3
    } cmd_t;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_UNMAPPED = 2'd1;
    localparam logic [1:0] STATUS_CROSS    = 2'd2;

    typedef logic [REG_SEGS-1:0][VADDR_W-1:0] base_arr_t;
    typedef logic [REG_SEGS-1:0][SIZE_W-1:0]  size_arr_t;

    typedef struct packed {
        logic                 hit;
        logic                 room_ok;
        logic [SEG_IDX_W-1:0] seg;
    } loc_info_t;

endpackage
`default_nettype wire

>>> src/segmented_memory_map_top.sv
// top level: segmented memory map with byte-serial access sequencer
//
//   channel | ports                                          | direction
//   s       | s_valid s_ready s_command s_address s_write_data | in
//   m       | m_valid m_ready m_read_data m_status           | out
//   apb     | psel penable pwrite paddr pwdata prdata pready | config
//
// reads touch one byte of the store per pass through locate, access and capture,
// and writes one byte per access state; the single store port sets this
// a new word is taken only once the previous one has reached the output register
// reset clears the state, output valid and config registers; the store is not cleared
// a stalled result holds in the output register; the next word may run meanwhile
`default_nettype none
module segmented_memory_map_top #(
    parameter int NUM_SEGMENTS = 4,
    parameter int SEG_BYTES    = 4096
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_command,
    input  wire logic [31:0]                   s_address,
    input  wire logic [31:0]                   s_write_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [31:0]                   m_read_data,
    output logic      [1:0]                    m_status,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [smm_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);
    import smm_pkg::*;

    localparam int NUM_ACTIVE = (NUM_SEGMENTS < REG_SEGS) ? NUM_SEGMENTS : REG_SEGS;
    localparam int DEPTH      = NUM_ACTIVE * SEG_BYTES;
    localparam int ADDR_W     = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOCATE,
        S_ACCESS,
        S_CAPTURE,
        S_DONE
    } state_t;

    state_t              state_reg;
    cmd_t                cmd_reg;
    logic [VADDR_W-1:0]  addr_reg;
    logic [DATA_W-1:0]   data_reg;
    logic [DATA_W-1:0]   rd_reg;
    logic [1:0]          st_reg;
    logic [1:0]          cnt_reg;
    logic [ADDR_W-1:0]   idx_reg;
    logic                m_valid_reg;
    logic [DATA_W-1:0]   m_read_data_reg;
    logic [1:0]          m_status_reg;

    base_arr_t           seg_base;
    size_arr_t           seg_size;
    loc_info_t           loc_info;
    logic [ADDR_W-1:0]   loc_index;
    logic                is_write;
    logic                mem_we;
    logic                mem_re;
    logic [7:0]          mem_wdata;
    logic [7:0]          mem_rdata;
    logic                out_load;

    smm_regs u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .seg_base (seg_base),
        .seg_size (seg_size)
    );

    smm_locate #(
        .NUM_SEGMENTS (NUM_SEGMENTS),
        .SEG_BYTES    (SEG_BYTES),
        .ADDR_W       (ADDR_W)
    ) u_locate (
        .address  (addr_reg),
        .seg_base (seg_base),
        .seg_size (seg_size),
        .info     (loc_info),
        .index    (loc_index)
    );

    smm_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (idx_reg),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign is_write  = (cmd_reg == CMD_WRITE_BYTE) || (cmd_reg == CMD_WRITE_WORD);
    assign mem_we    = (state_reg == S_ACCESS) && is_write;
    assign mem_re    = (state_reg == S_ACCESS) && !is_write;
    assign mem_wdata = (cmd_reg == CMD_WRITE_BYTE) ? data_reg[7:0] : data_reg[31:24];
    assign out_load  = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;
    assign m_status    = m_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        cmd_reg   <= cmd_t'(s_command);
                        addr_reg  <= s_address;
                        data_reg  <= s_write_data;
                        rd_reg    <= '0;
                        st_reg    <= STATUS_OK;
                        cnt_reg   <= '0;
                        state_reg <= S_LOCATE;
                    end
                end
                S_LOCATE: begin
                    idx_reg <= loc_index;
                    case (cmd_reg)
                        CMD_READ_BYTE, CMD_WRITE_BYTE: begin
                            if (loc_info.hit) begin
                                state_reg <= S_ACCESS;
                            end else begin
                                st_reg    <= STATUS_UNMAPPED;
                                state_reg <= S_DONE;
                            end
                        end
                        CMD_READ_WORD: begin
                            if (loc_info.hit) begin
                                state_reg <= S_ACCESS;
                            end else begin
                                // gap byte reads as zero
                                st_reg  <= STATUS_UNMAPPED;
                                rd_reg  <= {rd_reg[DATA_W-9:0], 8'h00};
                                cnt_reg <= cnt_reg + 2'd1;
                                addr_reg <= addr_reg + VADDR_W'(1);
                                if (cnt_reg == 2'd3) begin
                                    state_reg <= S_DONE;
                                end
                            end
                        end
                        CMD_WRITE_WORD: begin
                            if (!loc_info.hit) begin
                                st_reg    <= STATUS_UNMAPPED;
                                state_reg <= S_DONE;
                            end else if (!loc_info.room_ok) begin
                                st_reg    <= STATUS_CROSS;
                                state_reg <= S_DONE;
                            end else begin
                                state_reg <= S_ACCESS;
                            end
                        end
                        default: begin
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_ACCESS: begin
                    case (cmd_reg)
                        CMD_WRITE_BYTE: begin
                            state_reg <= S_DONE;
                        end
                        CMD_WRITE_WORD: begin
                            data_reg <= {data_reg[DATA_W-9:0], 8'h00};
                            idx_reg  <= idx_reg + ADDR_W'(1);
                            cnt_reg  <= cnt_reg + 2'd1;
                            if (cnt_reg == 2'd3) begin
                                state_reg <= S_DONE;
                            end
                        end
                        default: begin
                            state_reg <= S_CAPTURE;
                        end
                    endcase
                end
                S_CAPTURE: begin
                    rd_reg <= {rd_reg[DATA_W-9:0], mem_rdata};
                    if ((cmd_reg == CMD_READ_BYTE) || (cnt_reg == 2'd3)) begin
                        state_reg <= S_DONE;
                    end else begin
                        cnt_reg   <= cnt_reg + 2'd1;
                        addr_reg  <= addr_reg + VADDR_W'(1);
                        state_reg <= S_LOCATE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        m_read_data_reg <= rd_reg;
                        m_status_reg    <= st_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

>>> src/smm_regs.sv
// apb register file holding segment bases and sizes
`default_nettype none
module smm_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [smm_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    output smm_pkg::base_arr_t                 seg_base,
    output smm_pkg::size_arr_t                 seg_size
);
    import smm_pkg::*;

    base_arr_t             base_reg;
    size_arr_t             size_reg;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic [SEG_IDX_W-1:0]  seg_sel;
    logic                  is_size;

    assign reg_idx  = paddr[CFG_ADDR_W-1:2];
    assign seg_sel  = reg_idx[SEG_IDX_W-1:0];
    assign is_size  = (reg_idx >= REG_IDX_W'(REG_SEGS));
    assign pready   = 1'b1;
    assign seg_base = base_reg;
    assign seg_size = size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
            size_reg <= '0;
        end else if (psel && penable && pwrite) begin
            if (is_size) begin
                size_reg[seg_sel] <= pwdata[SIZE_W-1:0];
            end else begin
                base_reg[seg_sel] <= pwdata;
            end
        end
    end

    always_comb begin
        if (is_size) begin
            prdata = {{(32-SIZE_W){1'b0}}, size_reg[seg_sel]};
        end else begin
            prdata = base_reg[seg_sel];
        end
    end

endmodule
`default_nettype wire

>>> src/smm_locate.sv
// segment match, offset and store index for one byte address
`default_nettype none
module smm_locate #(
    parameter int NUM_SEGMENTS = 4,
    parameter int SEG_BYTES    = 4096,
    parameter int ADDR_W       = 14
) (
    input  wire logic [smm_pkg::VADDR_W-1:0] address,
    input  wire smm_pkg::base_arr_t          seg_base,
    input  wire smm_pkg::size_arr_t          seg_size,
    output smm_pkg::loc_info_t               info,
    output logic [ADDR_W-1:0]                index
);
    import smm_pkg::*;

    localparam int NUM_ACTIVE = (NUM_SEGMENTS < REG_SEGS) ? NUM_SEGMENTS : REG_SEGS;

    logic [VADDR_W-1:0] off   [NUM_ACTIVE];
    logic [VADDR_W-1:0] sz    [NUM_ACTIVE];
    logic [NUM_ACTIVE-1:0] match;
    logic [VADDR_W-1:0] sel_off;
    logic [VADDR_W-1:0] sel_sz;
    logic [SEG_IDX_W-1:0] sel_seg;
    logic [VADDR_W-1:0] flat_idx;

    always_comb begin
        for (int i = 0; i < NUM_ACTIVE; i++) begin
            off[i] = address - seg_base[i];
            if (VADDR_W'(seg_size[i]) > VADDR_W'(SEG_BYTES)) begin
                sz[i] = VADDR_W'(SEG_BYTES);
            end else begin
                sz[i] = VADDR_W'(seg_size[i]);
            end
            match[i] = (off[i] < sz[i]);
        end
    end

    // lowest-numbered matching segment wins
    always_comb begin
        sel_off = '0;
        sel_sz  = '0;
        sel_seg = '0;
        for (int i = NUM_ACTIVE - 1; i >= 0; i--) begin
            if (match[i]) begin
                sel_off = off[i];
                sel_sz  = sz[i];
                sel_seg = SEG_IDX_W'(i);
            end
        end
    end

    assign flat_idx     = VADDR_W'(sel_seg) * VADDR_W'(SEG_BYTES) + sel_off;
    assign index        = flat_idx[ADDR_W-1:0];
    assign info.hit     = |match;
    assign info.room_ok = ((sel_off + VADDR_W'(3)) < sel_sz);
    assign info.seg     = sel_seg;

endmodule
`default_nettype wire

>>> src/smm_store.sv
// byte store, one port, registered read
`default_nettype none
module smm_store #(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [7:0]        wdata,
    output logic      [7:0]        rdata
);
    logic [7:0] store_mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            store_mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= store_mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire
